// ===== rtl/htci_pkg.sv =====
// shared types and constants for the html class injector
// no dependencies
`timescale 1ns / 1ps
package htci_pkg;

  typedef enum logic [3:0] {
    M_NORMAL  = 4'd0,
    M_LT      = 4'd1,
    M_PCOM    = 4'd2,
    M_PCDATA  = 4'd3,
    M_PDOC    = 4'd4,
    M_PXML    = 4'd5,
    M_NAME    = 4'd6,
    M_TAG     = 4'd7,
    M_ANAME   = 4'd8,
    M_AEQ     = 4'd9,
    M_AVAL    = 4'd10,
    M_CLOSE   = 4'd11,
    M_SKIP    = 4'd12,
    M_COMMENT = 4'd13,
    M_CDATA   = 4'd14
  } mode_t;

  typedef enum logic [1:0] {
    INS_NONE  = 2'd0,
    INS_PRE   = 2'd1,
    INS_POST  = 2'd2,
    INS_SPACE = 2'd3
  } ins_t;

  localparam logic [1:0] CFG_NS_LENGTH = 2'd0;
  localparam logic [1:0] CFG_NS_LOW    = 2'd1;
  localparam logic [1:0] CFG_NS_HIGH   = 2'd2;

  localparam logic [3:0] SC_SCAN   = 4'd0;
  localparam logic [3:0] SC_ONE    = 4'd1;
  localparam logic [3:0] SC_TWO    = 4'd2;
  localparam logic [3:0] ATTR_DONE = 4'd15;

  // queued work between classifier and emitter
  typedef struct packed {
    logic [7:0] data;
    ins_t       ins;
    logic       last;
    logic       bad;
  } cmd_t;

  function automatic logic is_ws(input logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0d || b == 8'h0a;
  endfunction

  function automatic logic [7:0] cdata_char(input logic [3:0] k);
    case (k)
      4'd0: return "!";
      4'd1: return "[";
      4'd2: return "C";
      4'd3: return "D";
      4'd4: return "A";
      4'd5: return "T";
      4'd6: return "A";
      4'd7: return "[";
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] doc_char(input logic [3:0] k);
    case (k)
      4'd0: return "!";
      4'd1: return "D";
      4'd2: return "O";
      4'd3: return "C";
      4'd4: return "T";
      4'd5: return "Y";
      4'd6: return "P";
      4'd7: return "E";
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] xml_char(input logic [3:0] k);
    case (k)
      4'd0: return "?";
      4'd1: return "x";
      4'd2: return "m";
      4'd3: return "l";
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] com_char(input logic [3:0] k);
    case (k)
      4'd0: return "!";
      4'd1: return "-";
      4'd2: return "-";
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] class_char(input logic [3:0] k);
    case (k)
      4'd0: return "c";
      4'd1: return "l";
      4'd2: return "a";
      4'd3: return "s";
      4'd4: return "s";
      default: return 8'h00;
    endcase
  endfunction

endpackage

// ===== rtl/htci_front.sv =====
// classifier: parses one byte per cycle while take is high and decides the insertion kind
// depends on htci_pkg
`timescale 1ns / 1ps
module htci_front #(
  parameter int TAG_BUF     = 8,
  parameter int DEPTH_WIDTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           take,
  input  logic [7:0]     in_byte,
  input  logic           is_last,
  output htci_pkg::cmd_t cmd
);

  localparam int CW = $clog2(TAG_BUF + 2);
  localparam int IW = $clog2(TAG_BUF);
  localparam int DW = DEPTH_WIDTH + 1;

  htci_pkg::mode_t parse_mode, parse_mode_next;
  logic [3:0]      match_progress, match_progress_next;
  logic signed [DW-1:0] nesting_depth, nesting_depth_next;
  logic [7:0]      tag_name_store [TAG_BUF];
  logic [CW-1:0]   tag_name_count, tag_name_count_next;
  logic            tag_had_class, tag_had_class_next;
  logic            attr_is_class, attr_is_class_next;
  logic            value_pending, value_pending_next;
  logic [7:0]      quote_char, quote_char_next;
  logic [7:0]      previous_byte;
  logic            wr_en;
  logic [CW-1:0]   wr_idx;
  htci_pkg::ins_t  ins;

  function automatic logic word_is(input logic [7:0] st [TAG_BUF], input logic [CW-1:0] n,
                                   input logic [63:0] w, input int len);
    logic ok;
    ok = (n == CW'(len));
    for (int i = 0; i < 8; i++) begin
      if (i < len && i < TAG_BUF && st[i] != w[8*(7-i) +: 8]) ok = 1'b0;
    end
    return ok;
  endfunction

  logic ignored;
  always_comb begin
    ignored = word_is(tag_name_store, tag_name_count, {"html", 32'h0}, 4)
      || word_is(tag_name_store, tag_name_count, {"head", 32'h0}, 4)
      || word_is(tag_name_store, tag_name_count, {"base", 32'h0}, 4)
      || word_is(tag_name_store, tag_name_count, {"meta", 32'h0}, 4)
      || word_is(tag_name_store, tag_name_count, {"title", 24'h0}, 5)
      || word_is(tag_name_store, tag_name_count, {"link", 32'h0}, 4)
      || word_is(tag_name_store, tag_name_count, {"script", 16'h0}, 6)
      || word_is(tag_name_store, tag_name_count, "noscript", 8)
      || word_is(tag_name_store, tag_name_count, {"style", 24'h0}, 5);
  end

  localparam logic signed [DW-1:0] DMAX = {1'b0, {DEPTH_WIDTH{1'b1}}};
  localparam logic signed [DW-1:0] DMIN = {1'b1, {DEPTH_WIDTH{1'b0}}};

  always_comb begin
    htci_pkg::mode_t m;
    logic again;
    logic [7:0] b;
    logic [7:0] pc;
    logic [3:0] plen;
    htci_pkg::mode_t pnm;
    logic [3:0] pnp;
    logic [3:0] s;
    logic [7:0] mark;
    m = parse_mode;
    b = in_byte;
    match_progress_next = match_progress;
    nesting_depth_next  = nesting_depth;
    tag_name_count_next = tag_name_count;
    tag_had_class_next  = tag_had_class;
    attr_is_class_next  = attr_is_class;
    value_pending_next  = value_pending;
    quote_char_next     = quote_char;
    wr_en  = 1'b0;
    wr_idx = tag_name_count;
    ins    = htci_pkg::INS_NONE;
    pc = 8'h00; plen = 4'd0; pnm = htci_pkg::M_NORMAL; pnp = 4'd0;
    s = 4'd0; mark = 8'h00;
    again = 1'b1;
    // a byte is processed in at most four passes as modes fall through
    for (int it = 0; it < 4; it++) begin
      if (again) begin
        again = 1'b0;
        if (m == htci_pkg::M_PCDATA || m == htci_pkg::M_PDOC || m == htci_pkg::M_PXML ||
            (m == htci_pkg::M_PCOM && match_progress_next > 4'd1)) begin
          case (m)
            htci_pkg::M_PCDATA: begin
              pc = htci_pkg::cdata_char(match_progress_next); plen = 4'd8;
              pnm = htci_pkg::M_CDATA; pnp = htci_pkg::SC_SCAN;
            end
            htci_pkg::M_PDOC: begin
              pc = htci_pkg::doc_char(match_progress_next); plen = 4'd8;
              pnm = htci_pkg::M_SKIP; pnp = 4'd0;
            end
            htci_pkg::M_PXML: begin
              pc = htci_pkg::xml_char(match_progress_next); plen = 4'd4;
              pnm = htci_pkg::M_SKIP; pnp = 4'd0;
            end
            default: begin
              pc = htci_pkg::com_char(match_progress_next); plen = 4'd3;
              pnm = htci_pkg::M_COMMENT; pnp = htci_pkg::SC_TWO;
            end
          endcase
          if (match_progress_next < plen && b == pc) begin
            wr_en = 1'b1;
            if (match_progress_next + 4'd1 >= plen) begin
              m = pnm; match_progress_next = pnp;
            end else begin
              match_progress_next = match_progress_next + 4'd1;
            end
          end else begin
            m = htci_pkg::M_NAME; again = 1'b1;
          end
        end else begin
          case (m)
            htci_pkg::M_NORMAL: begin
              if (b == "<") begin
                m = htci_pkg::M_LT; tag_name_count_next = '0; match_progress_next = '0;
              end
            end
            htci_pkg::M_LT: begin
              if (b == "/") m = htci_pkg::M_CLOSE;
              else if (b == "!") begin
                wr_en = 1'b1; m = htci_pkg::M_PCOM; match_progress_next = 4'd1;
              end else if (b == "?") begin
                wr_en = 1'b1; m = htci_pkg::M_PXML; match_progress_next = 4'd1;
              end else begin
                m = htci_pkg::M_NAME; again = 1'b1;
              end
            end
            htci_pkg::M_PCOM: begin
              if (b == "[") begin
                wr_en = 1'b1; m = htci_pkg::M_PCDATA; match_progress_next = 4'd2;
              end else if (b == "D") begin
                wr_en = 1'b1; m = htci_pkg::M_PDOC; match_progress_next = 4'd2;
              end else if (b == "-") begin
                wr_en = 1'b1; match_progress_next = 4'd2;
              end else begin
                m = htci_pkg::M_NAME; again = 1'b1;
              end
            end
            htci_pkg::M_NAME: begin
              if (htci_pkg::is_ws(b) || b == ">" || b == "/") begin
                m = htci_pkg::M_TAG; again = 1'b1;
              end else wr_en = 1'b1;
            end
            htci_pkg::M_TAG: begin
              if (b == "/" || b == ">") begin
                if (nesting_depth_next == '0 && !tag_had_class_next && !ignored) begin
                  if (b == "/" && htci_pkg::is_ws(previous_byte)) ins = htci_pkg::INS_POST;
                  else ins = htci_pkg::INS_PRE;
                end
                tag_had_class_next = 1'b0;
                value_pending_next = 1'b0;
                if (b == "/") m = htci_pkg::M_SKIP;
                else begin
                  if (nesting_depth_next != DMAX) nesting_depth_next = nesting_depth_next + 1'b1;
                  m = htci_pkg::M_NORMAL;
                end
              end else if (!htci_pkg::is_ws(b)) begin
                attr_is_class_next = 1'b0; match_progress_next = '0;
                m = htci_pkg::M_ANAME; again = 1'b1;
              end
            end
            htci_pkg::M_ANAME: begin
              if (b == "=") m = htci_pkg::M_AEQ;
              else if (match_progress_next < 4'd5) begin
                if (b == htci_pkg::class_char(match_progress_next)) begin
                  if (match_progress_next == 4'd4) begin
                    attr_is_class_next = 1'b1; tag_had_class_next = 1'b1;
                    match_progress_next = htci_pkg::ATTR_DONE;
                  end else match_progress_next = match_progress_next + 4'd1;
                end else match_progress_next = htci_pkg::ATTR_DONE;
              end
            end
            htci_pkg::M_AEQ: begin
              if (b == 8'h27 || b == 8'h22) begin
                quote_char_next = b; value_pending_next = 1'b1; m = htci_pkg::M_AVAL;
              end
            end
            htci_pkg::M_AVAL: begin
              if (b == quote_char_next) begin
                if (attr_is_class_next && nesting_depth_next == '0) ins = htci_pkg::INS_SPACE;
                attr_is_class_next = 1'b0; m = htci_pkg::M_TAG;
              end
            end
            htci_pkg::M_CLOSE: begin
              if (b == ">") begin
                if (nesting_depth_next != DMIN) nesting_depth_next = nesting_depth_next - 1'b1;
                value_pending_next = 1'b0; m = htci_pkg::M_NORMAL;
              end
            end
            htci_pkg::M_SKIP: if (b == ">") m = htci_pkg::M_NORMAL;
            htci_pkg::M_COMMENT, htci_pkg::M_CDATA: begin
              mark = (m == htci_pkg::M_COMMENT) ? "-" : "]";
              s = match_progress_next;
              if (s == htci_pkg::SC_TWO && b == ">") begin
                m = htci_pkg::M_NORMAL; match_progress_next = '0;
              end else begin
                if (s == htci_pkg::SC_TWO) s = htci_pkg::SC_SCAN;
                if (s == htci_pkg::SC_ONE)
                  match_progress_next = (b == mark) ? htci_pkg::SC_TWO : htci_pkg::SC_SCAN;
                else
                  match_progress_next = (b == mark) ? htci_pkg::SC_ONE : htci_pkg::SC_SCAN;
              end
            end
            default: m = htci_pkg::M_NORMAL;
          endcase
        end
        if (wr_en) begin
          wr_idx = tag_name_count_next;
          if (tag_name_count_next <= CW'(TAG_BUF))
            tag_name_count_next = tag_name_count_next + 1'b1;
        end
      end
    end
    parse_mode_next = m;
  end

  logic bad;
  assign bad = parse_mode_next != htci_pkg::M_NORMAL || nesting_depth_next != '0 ||
               attr_is_class_next || value_pending_next;

  always_ff @(posedge clk) begin
    if (take && wr_en && wr_idx < CW'(TAG_BUF)) tag_name_store[wr_idx[IW-1:0]] <= in_byte;
    if (take) begin
      cmd.data <= in_byte;
      cmd.ins  <= ins;
      cmd.last <= is_last;
      cmd.bad  <= is_last && bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && is_last)) begin
      parse_mode     <= htci_pkg::M_NORMAL;
      match_progress <= '0;
      nesting_depth  <= '0;
      tag_name_count <= '0;
      tag_had_class  <= 1'b0;
      attr_is_class  <= 1'b0;
      value_pending  <= 1'b0;
      quote_char     <= '0;
      previous_byte  <= '0;
    end else if (take) begin
      parse_mode     <= parse_mode_next;
      match_progress <= match_progress_next;
      nesting_depth  <= nesting_depth_next;
      tag_name_count <= tag_name_count_next;
      tag_had_class  <= tag_had_class_next;
      attr_is_class  <= attr_is_class_next;
      value_pending  <= value_pending_next;
      quote_char     <= quote_char_next;
      previous_byte  <= in_byte;
    end
  end

endmodule

// ===== rtl/htci_fifo.sv =====
// small command queue between classifier and emitter
// depends on htci_pkg
`timescale 1ns / 1ps
module htci_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  htci_pkg::cmd_t wdata,
  input  logic           rd,
  output htci_pkg::cmd_t rdata,
  output logic           full,
  output logic           empty
);

  localparam int AW = $clog2(DEPTH);

  htci_pkg::cmd_t mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   count;

  assign full  = count == (AW+1)'(DEPTH);
  assign empty = count == '0;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (wr && !full) mem[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; count <= '0;
    end else begin
      if (wr && !full) wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      if (rd && !empty) rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      count <= count + (AW+1)'(wr && !full) - (AW+1)'(rd && !empty);
    end
  end

endmodule

// ===== rtl/htci_back.sv =====
// emitter: expands one command into its output bytes, one per pop
// depends on htci_pkg
`timescale 1ns / 1ps
module htci_back #(
  parameter int NS_MAX = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  htci_pkg::cmd_t cmd,
  input  logic           cmd_valid,
  output logic           cmd_take,
  input  logic [4:0]     ns_length,
  input  logic [127:0]   ns_chars,
  output logic           empty,
  input  logic           pop,
  output logic [7:0]     out_byte,
  output logic           last_of_run,
  output logic           status_valid,
  output logic           end_status
);

  logic [4:0] pos;
  logic [4:0] nlen;
  logic [4:0] total;
  logic [4:0] ci;
  logic [7:0] ch;

  assign nlen = (ns_length > 5'(NS_MAX)) ? 5'(NS_MAX) : ns_length;

  always_comb begin
    case (cmd.ins)
      htci_pkg::INS_PRE:   total = nlen + 5'd9;
      htci_pkg::INS_POST:  total = nlen + 5'd9;
      htci_pkg::INS_SPACE: total = nlen + 5'd1;
      default:             total = 5'd0;
    endcase
  end

  always_comb begin
    ci = '0;
    ch = cmd.data;
    if (pos < total) begin
      case (cmd.ins)
        htci_pkg::INS_PRE: begin
          if (pos < 5'd8) ch = htci_pkg::class_char(4'(pos) - 4'd1);
          else if (pos < nlen + 5'd8) begin
            ci = pos - 5'd8; ch = ns_chars[8*ci[3:0] +: 8];
          end else ch = 8'h22;
          if (pos == 5'd0) ch = " ";
          else if (pos == 5'd6) ch = "=";
          else if (pos == 5'd7) ch = 8'h22;
        end
        htci_pkg::INS_POST: begin
          if (pos < 5'd5) ch = htci_pkg::class_char(4'(pos));
          else if (pos == 5'd5) ch = "=";
          else if (pos == 5'd6) ch = 8'h22;
          else if (pos < nlen + 5'd7) begin
            ci = pos - 5'd7; ch = ns_chars[8*ci[3:0] +: 8];
          end else if (pos == nlen + 5'd7) ch = 8'h22;
          else ch = " ";
        end
        htci_pkg::INS_SPACE: begin
          if (pos == 5'd0) ch = " ";
          else begin
            ci = pos - 5'd1; ch = ns_chars[8*ci[3:0] +: 8];
          end
        end
        default: ch = cmd.data;
      endcase
    end
  end

  logic fin;
  assign fin          = pos == total;
  assign empty        = !cmd_valid;
  assign out_byte     = ch;
  assign last_of_run  = fin;
  assign status_valid = fin && cmd.last;
  assign end_status   = fin && cmd.bad;
  assign cmd_take     = cmd_valid && pop && fin;

  always_ff @(posedge clk) begin
    if (rst) pos <= '0;
    else if (cmd_valid && pop) pos <= fin ? '0 : pos + 1'b1;
  end

endmodule

// ===== rtl/html_top_level_class_injector.sv =====
// top level of the html class injector: config registers, classifier, queue, emitter
// depends on htci_pkg, htci_front, htci_fifo, htci_back
`timescale 1ns / 1ps
// Bytes stream in through push/full and out through empty/pop, one per cycle each
// side when not stalled. A taken byte is registered in the classifier stage, then
// queued. A byte that opens a namespace insertion yields n+10 results (n+2 for
// the closing quote of a class value), where n is ns_length capped at NS_MAX; the
// emitter sends them one per cycle while pop is high. Meanwhile the classifier
// keeps taking bytes until its output stage and the 4-entry command queue are both
// full, then full stays high until the emitter frees a queue slot. Plain text
// sustains one byte per cycle when not stalled. Config writes are always ready.
module html_top_level_class_injector #(
  parameter int NS_MAX      = 16,
  parameter int TAG_BUF     = 8,
  parameter int DEPTH_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  input  logic        is_last,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        last_of_run,
  output logic        status_valid,
  output logic        end_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [4:0]  ns_length;
  logic [63:0] ns_chars_low, ns_chars_high;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ns_length <= 5'd1; ns_chars_low <= '0; ns_chars_high <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        htci_pkg::CFG_NS_LENGTH: ns_length     <= cfg_data[4:0];
        htci_pkg::CFG_NS_LOW:    ns_chars_low  <= cfg_data;
        htci_pkg::CFG_NS_HIGH:   ns_chars_high <= cfg_data;
        default: ;
      endcase
    end
  end

  logic take;
  logic cmd_in_valid;
  htci_pkg::cmd_t fcmd, qcmd;
  logic q_full, q_empty, q_take;

  assign full = q_full && cmd_in_valid;
  assign take = push && !full;

  htci_front #(.TAG_BUF(TAG_BUF), .DEPTH_WIDTH(DEPTH_WIDTH)) u_front (
    .clk, .rst, .take, .in_byte, .is_last, .cmd(fcmd)
  );

  // the front register is a stage; it drains into the queue
  always_ff @(posedge clk) begin
    if (rst) cmd_in_valid <= 1'b0;
    else if (take) cmd_in_valid <= 1'b1;
    else if (!q_full) cmd_in_valid <= 1'b0;
  end

  htci_fifo #(.DEPTH(4)) u_fifo (
    .clk, .rst, .wr(cmd_in_valid && !q_full), .wdata(fcmd), .rd(q_take),
    .rdata(qcmd), .full(q_full), .empty(q_empty)
  );

  htci_back #(.NS_MAX(NS_MAX)) u_back (
    .clk, .rst, .cmd(qcmd), .cmd_valid(!q_empty), .cmd_take(q_take),
    .ns_length, .ns_chars({ns_chars_high, ns_chars_low}),
    .empty, .pop, .out_byte, .last_of_run, .status_valid, .end_status
  );

  a_status_on_last: assert property (@(posedge clk) disable iff (rst)
    status_valid |-> last_of_run) else $error("status without last");
  a_bad_needs_status: assert property (@(posedge clk) disable iff (rst)
    end_status |-> status_valid) else $error("end status without valid");
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    full |-> cmd_in_valid) else $error("full without pending command");

endmodule
